/* hdl/tkp_pkg.sv */
`timescale 1ns / 1ps

package tkp_pkg;

    localparam int CAPACITY_DEF = 10;

    localparam int X_W     = 11;
    localparam int Y_W     = 11;
    localparam int ANGLE_W = 16;
    localparam int SCORE_W = 16;
    localparam int HALF_W  = 10;
    localparam int CMD_W   = 2;
    localparam int CFG_IDX_W = 2;
    localparam int COORD_W = 13;

    localparam logic [HALF_W-1:0] HALF_RESET = 10'd50;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TAKE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_HEIGHT = 2'd1;

    localparam logic [2:0] OP_HOLD   = 3'd0;
    localparam logic [2:0] OP_INSERT = 3'd1;
    localparam logic [2:0] OP_TAKE   = 3'd2;
    localparam logic [2:0] OP_MARK   = 3'd3;
    localparam logic [2:0] OP_SWAP   = 3'd4;
    localparam logic [2:0] OP_CLEAR  = 3'd5;

    typedef struct packed {
        logic [X_W-1:0]     x;
        logic [Y_W-1:0]     y;
        logic [ANGLE_W-1:0] angle;
        logic [SCORE_W-1:0] score;
    } entry_t;

    typedef struct packed {
        logic [2:0] op;
        logic       phase;
    } ctrl_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] right;
        logic signed [COORD_W-1:0] up;
        logic signed [COORD_W-1:0] down;
    } window_t;

endpackage

/* hdl/tkp_cell.sv */
`timescale 1ns / 1ps

module tkp_cell
    import tkp_pkg::*;
#(
    parameter bit PARITY = 1'b0
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  ctrl_t   ctrl,
    input  entry_t  new_ent,
    input  window_t win,
    input  entry_t  prev_ent,
    input  logic    prev_valid,
    input  logic    prev_lt,
    input  entry_t  next_ent,
    input  logic    next_valid,
    output entry_t  ent,
    output logic    valid,
    output logic    lt,
    output logic    keep
);

    entry_t ent_reg;
    entry_t ent_next;
    logic   valid_reg;
    logic   valid_next;
    logic   in_win;
    logic signed [COORD_W-1:0] ex;
    logic signed [COORD_W-1:0] ey;

    assign ex = $signed({{(COORD_W-X_W){1'b0}}, ent_reg.x});
    assign ey = $signed({{(COORD_W-Y_W){1'b0}}, ent_reg.y});

    assign in_win = (ex > win.left) && (ex < win.right) && (ey > win.up) && (ey < win.down);
    assign lt     = !valid_reg || (ent_reg.score < new_ent.score);
    assign keep   = valid_reg && !in_win;

    assign ent   = ent_reg;
    assign valid = valid_reg;

    always_comb
    begin
        ent_next   = ent_reg;
        valid_next = valid_reg;
        unique case (ctrl.op)
            OP_INSERT:
            begin
                if (lt)
                begin
                    if (!prev_lt)
                    begin
                        ent_next   = new_ent;
                        valid_next = 1'b1;
                    end
                    else
                    begin
                        ent_next   = prev_ent;
                        valid_next = prev_valid;
                    end
                end
            end
            OP_TAKE:
            begin
                ent_next   = next_ent;
                valid_next = next_valid;
            end
            OP_MARK:
            begin
                valid_next = keep;
            end
            OP_SWAP:
            begin
                // odd-even exchange: holes sink toward the tail
                if (ctrl.phase == PARITY)
                begin
                    if (!valid_reg && next_valid)
                    begin
                        ent_next   = next_ent;
                        valid_next = 1'b1;
                    end
                end
                else if (!prev_valid && valid_reg)
                begin
                    ent_next   = prev_ent;
                    valid_next = 1'b0;
                end
            end
            OP_CLEAR:
            begin
                valid_next = 1'b0;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

endmodule

/* hdl/top_k_scored_pose_list.sv */
// Insert, take and clear: the result is registered and
// shown the cycle after the item is accepted.
// Remove near: marked cells are compacted by odd-even passes along the cell
// chain; in_stall holds off new items until the compaction is done.
// Reset: list empty, both half sizes 50; entries need no clearing pass.
`timescale 1ns / 1ps

module top_k_scored_pose_list
    import tkp_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [CMD_W-1:0]     cmd,
    input  logic [X_W-1:0]       pos_x,
    input  logic [Y_W-1:0]       pos_y,
    input  logic [ANGLE_W-1:0]   angle,
    input  logic [SCORE_W-1:0]   score,

    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 found,
    output logic [X_W-1:0]       out_x,
    output logic [Y_W-1:0]       out_y,
    output logic [ANGLE_W-1:0]   out_angle,
    output logic [SCORE_W-1:0]   out_score,
    output logic [CNT_W-1:0]     entry_count,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [HALF_W-1:0]    cfg_data
);

    localparam int CYC_W = $clog2(CAPACITY + 1);
    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_SWEEP = 1'b1;

    logic                state_reg;
    logic                state_next;
    logic [CYC_W-1:0]    cyc_reg;
    logic [CYC_W-1:0]    cyc_next;
    logic [CAPACITY-1:0] sr_reg;
    logic [CAPACITY-1:0] sr_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [HALF_W-1:0]   hw_reg;
    logic [HALF_W-1:0]   hh_reg;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic                found_reg;
    logic                found_next;
    entry_t              out_ent_reg;
    entry_t              out_ent_next;
    logic [CNT_W-1:0]    out_cnt_reg;
    logic [CNT_W-1:0]    out_cnt_next;

    logic                accept;
    logic                sweep_done;
    ctrl_t               ctrl;
    entry_t              new_ent;
    window_t             win;

    entry_t              ent_w [CAPACITY];
    logic [CAPACITY-1:0] valid_w;
    logic [CAPACITY-1:0] lt_w;
    logic [CAPACITY-1:0] keep_w;

    assign in_stall  = (state_reg != ST_IDLE) || (out_valid_reg && out_stall);
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign new_ent.x     = pos_x;
    assign new_ent.y     = pos_y;
    assign new_ent.angle = angle;
    assign new_ent.score = score;

    assign win.left  = $signed({2'b00, pos_x}) - $signed({3'b000, hw_reg});
    assign win.right = $signed({2'b00, pos_x}) + $signed({3'b000, hw_reg});
    assign win.up    = $signed({2'b00, pos_y}) - $signed({3'b000, hh_reg});
    assign win.down  = $signed({2'b00, pos_y}) + $signed({3'b000, hh_reg});

    assign sweep_done = (state_reg == ST_SWEEP) && (cyc_reg == CYC_W'(CAPACITY - 1));

    always_comb
    begin
        ctrl.op    = OP_HOLD;
        ctrl.phase = cyc_reg[0];
        if (state_reg == ST_SWEEP)
        begin
            ctrl.op = OP_SWAP;
        end
        else if (accept)
        begin
            unique case (cmd)
                CMD_INSERT: ctrl.op = OP_INSERT;
                CMD_TAKE:   ctrl.op = OP_TAKE;
                CMD_REMOVE: ctrl.op = OP_MARK;
                CMD_CLEAR:  ctrl.op = OP_CLEAR;
                default:    ctrl.op = OP_HOLD;
            endcase
        end
    end

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            entry_t prev_ent;
            logic   prev_valid;
            logic   prev_lt;
            entry_t next_ent;
            logic   next_valid;

            if (i == 0)
            begin : g_first
                assign prev_ent   = '0;
                assign prev_valid = 1'b1;
                assign prev_lt    = 1'b0;
            end
            else
            begin : g_mid
                assign prev_ent   = ent_w[i-1];
                assign prev_valid = valid_w[i-1];
                assign prev_lt    = lt_w[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_last
                assign next_ent   = '0;
                assign next_valid = 1'b0;
            end
            else
            begin : g_body
                assign next_ent   = ent_w[i+1];
                assign next_valid = valid_w[i+1];
            end

            tkp_cell #(
                .PARITY (1'(i % 2))
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .new_ent    (new_ent),
                .win        (win),
                .prev_ent   (prev_ent),
                .prev_valid (prev_valid),
                .prev_lt    (prev_lt),
                .next_ent   (next_ent),
                .next_valid (next_valid),
                .ent        (ent_w[i]),
                .valid      (valid_w[i]),
                .lt         (lt_w[i]),
                .keep       (keep_w[i])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        cyc_next       = cyc_reg;
        sr_next        = sr_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && out_stall;
        found_next     = found_reg;
        out_ent_next   = out_ent_reg;
        out_cnt_next   = out_cnt_reg;

        if (state_reg == ST_SWEEP)
        begin
            // serial count of survivors while the chain compacts
            sr_next    = sr_reg >> 1;
            count_next = count_reg + CNT_W'(sr_reg[0]);
            cyc_next   = cyc_reg + CYC_W'(1);
            if (sweep_done)
            begin
                state_next     = ST_IDLE;
                out_valid_next = 1'b1;
                found_next     = 1'b0;
                out_ent_next   = '0;
                out_cnt_next   = count_next;
            end
        end
        else if (accept)
        begin
            found_next   = 1'b0;
            out_ent_next = '0;
            unique case (cmd)
                CMD_INSERT:
                begin
                    if (count_reg != CNT_W'(CAPACITY))
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                CMD_TAKE:
                begin
                    if (valid_w[0])
                    begin
                        found_next   = 1'b1;
                        out_ent_next = ent_w[0];
                        count_next   = count_reg - CNT_W'(1);
                    end
                end
                CMD_REMOVE:
                begin
                    sr_next    = keep_w;
                    count_next = '0;
                    cyc_next   = '0;
                    state_next = ST_SWEEP;
                end
                CMD_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
            if (cmd != CMD_REMOVE)
            begin
                out_valid_next = 1'b1;
                out_cnt_next   = count_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cyc_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            hw_reg        <= HALF_RESET;
            hh_reg        <= HALF_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            cyc_reg       <= cyc_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_HALF_WIDTH)
                begin
                    hw_reg <= cfg_data;
                end
                else if (cfg_index == REG_HALF_HEIGHT)
                begin
                    hh_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sr_reg      <= sr_next;
        found_reg   <= found_next;
        out_ent_reg <= out_ent_next;
        out_cnt_reg <= out_cnt_next;
    end

    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign out_x       = out_ent_reg.x;
    assign out_y       = out_ent_reg.y;
    assign out_angle   = out_ent_reg.angle;
    assign out_score   = out_ent_reg.score;
    assign entry_count = out_cnt_reg;

endmodule

/* tb/sv/top_k_scored_pose_list_test.sv */
`timescale 1ns / 1ps

module top_k_scored_pose_list_test;
    import tkp_pkg::*;

    localparam int CNT_W      = $clog2(CAPACITY_DEF + 1);
    localparam int IDLE_LIMIT = 4000;
    localparam int PHASES     = 6;
    localparam int PHASE_ITEMS = 255;
    localparam int HOLD_CYCLES = 300;

    // indexes past the two half-size registers; the block ignores them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef struct packed {
        logic             found;
        entry_t           pose;
        logic [CNT_W-1:0] count;
    } result_t;

    class pose_list_board;
        entry_t  slots[CAPACITY_DEF];
        int      held;
        int      half_w;
        int      half_h;
        result_t expected_q[$];
        int      mismatches;
        int      items_seen;
        int      results_seen;
        int      takes_hit;
        int      full_inserts;
        int      discards;
        int      window_hits;

        function new();
            held = 0;
            half_w = int'(HALF_RESET);
            half_h = int'(HALF_RESET);
            mismatches = 0;
            items_seen = 0;
            results_seen = 0;
            takes_hit = 0;
            full_inserts = 0;
            discards = 0;
            window_hits = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [HALF_W-1:0] data);
            case (idx)
                REG_HALF_WIDTH:  half_w = int'(data);
                REG_HALF_HEIGHT: half_h = int'(data);
                default: ;
            endcase
        endfunction

        function void note_input(logic [CMD_W-1:0] c, entry_t e);
            result_t r;
            int      pos;
            int      last;
            int      kept;
            int      left;
            int      right;
            int      up;
            int      down;
            r = '0;
            items_seen++;
            case (c)
                CMD_INSERT:
                begin
                    pos = held;
                    for (int i = 0; i < held; i++)
                    begin
                        if (slots[i].score < e.score)
                        begin
                            pos = i;
                            break;
                        end
                    end
                    if (held == CAPACITY_DEF)
                        full_inserts++;
                    if (pos >= CAPACITY_DEF)
                        discards++;
                    else
                    begin
                        last = (held < CAPACITY_DEF) ? held : CAPACITY_DEF - 1;
                        for (int i = last; i > pos; i--)
                            slots[i] = slots[i - 1];
                        slots[pos] = e;
                        if (held < CAPACITY_DEF)
                            held++;
                    end
                end
                CMD_TAKE:
                begin
                    if (held != 0)
                    begin
                        r.found = 1'b1;
                        r.pose = slots[0];
                        for (int i = 1; i < held; i++)
                            slots[i - 1] = slots[i];
                        held--;
                        takes_hit++;
                    end
                end
                CMD_REMOVE:
                begin
                    left  = int'(e.x) - half_w;
                    right = int'(e.x) + half_w;
                    up    = int'(e.y) - half_h;
                    down  = int'(e.y) + half_h;
                    kept = 0;
                    for (int i = 0; i < held; i++)
                    begin
                        if (int'(slots[i].x) > left && int'(slots[i].x) < right &&
                            int'(slots[i].y) > up && int'(slots[i].y) < down)
                            window_hits++;
                        else
                        begin
                            slots[kept] = slots[i];
                            kept++;
                        end
                    end
                    held = kept;
                end
                default:
                    held = 0;
            endcase
            r.count = CNT_W'(held);
            expected_q = {expected_q, r};
        endfunction

        function void report(string what, result_t want, result_t got);
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("%s at result %0d:", what, results_seen);
                $display("    expected found=%0b x=%0d y=%0d angle=%h score=%h count=%0d",
                         want.found, want.pose.x, want.pose.y,
                         want.pose.angle, want.pose.score, want.count);
                $display("    actual   found=%0b x=%0d y=%0d angle=%h score=%h count=%0d",
                         got.found, got.pose.x, got.pose.y, got.pose.angle,
                         got.pose.score, got.count);
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            results_seen++;
            if (expected_q.size() == 0)
            begin
                report("unexpected result", '0, got);
                return;
            end
            want = expected_q.pop_front();
            if (got.found !== want.found || got.pose.x !== want.pose.x ||
                got.pose.y !== want.pose.y || got.pose.angle !== want.pose.angle ||
                got.pose.score !== want.pose.score || got.count !== want.count)
                report("mismatch", want, got);
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [CMD_W-1:0]     cmd;
    logic [X_W-1:0]       pos_x;
    logic [Y_W-1:0]       pos_y;
    logic [ANGLE_W-1:0]   angle;
    logic [SCORE_W-1:0]   score;
    logic                 out_valid;
    logic                 out_stall;
    logic                 found;
    logic [X_W-1:0]       out_x;
    logic [Y_W-1:0]       out_y;
    logic [ANGLE_W-1:0]   out_angle;
    logic [SCORE_W-1:0]   out_score;
    logic [CNT_W-1:0]     entry_count;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [HALF_W-1:0]    cfg_data;

    pose_list_board board = new();

    int src_idle_pct;
    int sink_stall_pct;
    int hold_left;

    int phase_hw[PHASES]         = '{50, 0, 1023, 1, 1023, 50};
    int phase_hh[PHASES]         = '{50, 1023, 0, 1, 1023, 50};
    int phase_src_idle[PHASES]   = '{0, 81, 0, 29, 0, 81};
    int phase_sink_stall[PHASES] = '{0, 0, 81, 29, 0, 0};

    top_k_scored_pose_list dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .angle       (angle),
        .score       (score),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .found       (found),
        .out_x       (out_x),
        .out_y       (out_y),
        .out_angle   (out_angle),
        .out_score   (out_score),
        .entry_count (entry_count),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic send_item(input logic [CMD_W-1:0] c, input int x, input int y,
                             input int a, input int s);
        entry_t e;
        e.x = X_W'(x);
        e.y = Y_W'(y);
        e.angle = ANGLE_W'(a);
        e.score = SCORE_W'(s);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        pos_x <= e.x;
        pos_y <= e.y;
        angle <= e.angle;
        score <= e.score;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_input(c, e);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (board.expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [HALF_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.write_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // receiver: random stall, or a long hold-off when requested
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(99) < sink_stall_pct);
        end
    end

    initial
    begin
        result_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                got.found = found;
                got.pose.x = out_x;
                got.pose.y = out_y;
                got.pose.angle = out_angle;
                got.pose.score = out_score;
                got.count = entry_count;
                board.check_result(got);
            end
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: no handshake for %0d cycles, %0d results outstanding",
                         IDLE_LIMIT, board.expected_q.size());
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        entry_t           e;
        logic [CMD_W-1:0] c;
        int               roll;
        int               pick;
        int               k;
        int               ins_pct;
        logic [15:0]      tie_levels[4];

        tie_levels = '{16'h0000, 16'h4000, 16'h8000, 16'hFFFF};
        in_valid = 1'b0;
        cmd = CMD_INSERT;
        pos_x = '0;
        pos_y = '0;
        angle = '0;
        score = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_HALF_WIDTH;
        cfg_data = '0;
        src_idle_pct = 0;
        sink_stall_pct = 0;
        hold_left = 0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed, reset window of 50
        send_item(CMD_TAKE,   0,    0,    0,       0);
        send_item(CMD_REMOVE, 100,  100,  0,       0);
        send_item(CMD_INSERT, 0,    0,    0,       0);
        send_item(CMD_INSERT, 2047, 2047, 'hFFFF,  'hFFFF);
        send_item(CMD_INSERT, 30,   40,   'h1111,  'h8000);
        send_item(CMD_INSERT, 1000, 1000, 'h2222,  'h8000);
        send_item(CMD_INSERT, 1020, 980,  'h3333,  'h8000);
        send_item(CMD_TAKE,   0,    0,    0,       0);
        send_item(CMD_INSERT, 2040, 2030, 'h5555,  'h1000);
        send_item(CMD_INSERT, 1365, 682,  'hAAAA,  'h2000);
        send_item(CMD_INSERT, 682,  1365, 'h5A5A,  'h3000);
        send_item(CMD_INSERT, 10,   2047, 'hA5A5,  'h4000);
        send_item(CMD_INSERT, 2047, 10,   'h0F0F,  'h9000);
        send_item(CMD_INSERT, 500,  45,   'hF0F0,  'h7FFF);
        send_item(CMD_INSERT, 1500, 1500, 'h1234,  'h0000);
        send_item(CMD_INSERT, 1600, 1600, 'h4321,  'h0001);
        send_item(CMD_REMOVE, 0,    0,    0,       0);
        send_item(CMD_REMOVE, 1010, 990,  0,       0);
        send_item(CMD_REMOVE, 2047, 2047, 0,       0);
        send_item(CMD_REMOVE, 500,  0,    0,       0);
        send_item(CMD_TAKE,   0,    0,    0,       0);
        send_item(CMD_TAKE,   0,    0,    0,       0);
        send_item(CMD_CLEAR,  2047, 2047, 'hFFFF,  'hFFFF);
        send_item(CMD_TAKE,   0,    0,    0,       0);
        send_item(CMD_INSERT, 2047, 0,    'hFFFF,  'h0000);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain();
            if (ph == PHASES - 1)
            begin
                phase_hw[ph] = $urandom_range(400, 2);
                phase_hh[ph] = $urandom_range(400, 2);
            end
            if (ph != 0)
            begin
                write_cfg(REG_HALF_WIDTH, HALF_W'(phase_hw[ph]));
                write_cfg(REG_HALF_HEIGHT, HALF_W'(phase_hh[ph]));
            end
            if (ph == 2)
            begin
                write_cfg(REG_SPARE_A, 10'h3FF);
                write_cfg(REG_SPARE_B, 10'h000);
            end
            src_idle_pct = phase_src_idle[ph];
            sink_stall_pct = phase_sink_stall[ph];

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (ph == 0 && n == 120)
                    hold_left = HOLD_CYCLES;
                ins_pct = (board.held < 6) ? 65 : 45;
                roll = $urandom_range(99);
                if (roll < ins_pct)
                    c = CMD_INSERT;
                else if (roll < 78)
                    c = CMD_TAKE;
                else if (roll < 98)
                    c = CMD_REMOVE;
                else
                    c = CMD_CLEAR;

                pick = $urandom_range(9);
                e.x = X_W'((pick < 2) ? $urandom_range(63) :
                           (pick < 3) ? $urandom_range(2047, 1984) : $urandom_range(2047));
                pick = $urandom_range(9);
                e.y = Y_W'((pick < 2) ? $urandom_range(63) :
                           (pick < 3) ? $urandom_range(2047, 1984) : $urandom_range(2047));
                e.angle = ANGLE_W'($urandom);
                e.score = SCORE_W'(($urandom_range(9) < 3) ?
                                   32'(tie_levels[$urandom_range(3)]) : $urandom);

                // aim most window removals at a held pose
                if (c == CMD_REMOVE && board.held != 0 && $urandom_range(3) != 0)
                begin
                    k = $urandom_range(board.held - 1);
                    e.x = X_W'(board.slots[k].x ^ ($urandom_range(1) ? 0 : $urandom_range(31)));
                    e.y = Y_W'(board.slots[k].y ^ ($urandom_range(1) ? 0 : $urandom_range(31)));
                end
                send_item(c, int'(e.x), int'(e.y), int'(e.angle), int'(e.score));
            end
        end

        drain();
        repeat (2 * (CAPACITY_DEF + 1)) @(posedge clk);

        $display("Ran %0d items and checked %0d results over %0d window settings.",
                 board.items_seen, board.results_seen, PHASES);
        $display("Takes with an entry: %0d, inserts on a full list: %0d (%0d dropped),",
                 board.takes_hit, board.full_inserts, board.discards);
        $display("window removals: %0d.", board.window_hits);
        if (board.mismatches == 0 && board.expected_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* files.f */
hdl/tkp_pkg.sv
hdl/tkp_cell.sv
hdl/top_k_scored_pose_list.sv
tb/sv/top_k_scored_pose_list_test.sv
